// ===== hdl/rsi_pkg.sv =====
// ============================================================================
// rsi_pkg
// Shared widths, payload structs and pipeline sideband types for the
// ray-sphere intersection pipeline.
// ============================================================================
package rsi_pkg;

    // Coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_IN_W  = COORD_W - 1;

    // Dot product and quadratic coefficient widths
    localparam int OC_W   = COORD_W + 1;        // origin - center
    localparam int A_W    = 2 * COORD_W;        // d.d, unsigned
    localparam int B_W    = 2 * COORD_W + 3;    // 2*(oc.d), signed
    localparam int C_W    = B_W;                // oc.oc - r*r, signed
    localparam int OCSQ_W = 2 * OC_W;           // oc.oc, unsigned
    localparam int RR_W   = 2 * RAD_IN_W;       // r*r, unsigned

    // Limb multiplier
    localparam int MUL_W  = B_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LIMB_W = 32;
    localparam int NLIMB  = (MUL_W + LIMB_W - 1) / LIMB_W;

    // Square root and divide
    localparam int ROOT_W = B_W;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int NUM_W  = ROOT_W + 2;         // -b -/+ s, signed
    localparam int SHN_W  = NUM_W + FRAC_BITS;  // numerator scaled to Q.F
    localparam int DIVN_W = SHN_W - 1;          // positive numerator
    localparam int DEN_W  = A_W + 1;            // 2a
    localparam int QUO_W  = COORD_W - 1;        // distance field
    localparam int REM_W  = DEN_W + 1;

    // Input item
    typedef struct packed {
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  origin_z;
        logic signed [COORD_W-1:0]  dir_x;
        logic signed [COORD_W-1:0]  dir_y;
        logic signed [COORD_W-1:0]  dir_z;
        logic signed [COORD_W-1:0]  center_x;
        logic signed [COORD_W-1:0]  center_y;
        logic signed [COORD_W-1:0]  center_z;
        logic        [RAD_IN_W-1:0] sphere_radius;
    } t_ray_in;

    // Result item
    typedef struct packed {
        logic             hit;
        logic [QUO_W-1:0] distance;
        logic             zero_direction;
    } t_ray_out;

    // Sideband carried through a multiplier
    typedef struct packed {
        logic                  v;
        logic [A_W-1:0]        a;
        logic signed [B_W-1:0] b;
    } t_mul_side;

    // Sideband carried through the square root
    typedef struct packed {
        logic                  v;
        logic                  zero;
        logic                  neg;
        logic [A_W-1:0]        a;
        logic signed [B_W-1:0] b;
    } t_sqrt_side;

    // Sideband carried through the divider
    typedef struct packed {
        logic v;
        logic hit;
        logic zero;
    } t_div_side;

endpackage

// ===== hdl/rsi_mul.sv =====
// ============================================================================
// rsi_mul
// Pipelined signed multiplier built from 32x32 limb products.
// Stages: magnitude, limb products, row sums, total, sign.
// ============================================================================
module rsi_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic signed [rsi_pkg::MUL_W-1:0]   i_a,
    input  logic signed [rsi_pkg::MUL_W-1:0]   i_b,
    input  rsi_pkg::t_mul_side                 i_side,
    output logic signed [rsi_pkg::PROD_W-1:0]  o_p,
    output rsi_pkg::t_mul_side                 o_side
);
    localparam int MW   = rsi_pkg::MUL_W;
    localparam int LW   = rsi_pkg::LIMB_W;
    localparam int NL   = rsi_pkg::NLIMB;
    localparam int PADW = NL * LW;
    localparam int SUMW = 2 * PADW;
    localparam int LAT  = 5;

    logic [MW-1:0]     w_abs_a, w_abs_b;
    logic [PADW-1:0]   r_ma, r_mb;
    logic [2*LW-1:0]   r_pp  [NL][NL];
    logic [SUMW-1:0]   n_row [NL];
    logic [SUMW-1:0]   r_row [NL];
    logic [SUMW-1:0]   n_mag, r_mag;
    logic [SUMW-1:0]   w_sgn;
    logic [LAT-2:0]    r_neg;
    logic signed [rsi_pkg::PROD_W-1:0] r_p;
    rsi_pkg::t_mul_side r_side [LAT];

    // operand magnitudes
    assign w_abs_a = i_a[MW-1] ? MW'(-i_a) : MW'(i_a);
    assign w_abs_b = i_b[MW-1] ? MW'(-i_b) : MW'(i_b);

    // row sums of the limb products
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NL; j++) begin
                n_row[i] = n_row[i] + (SUMW'(r_pp[i][j]) << (j * LW));
            end
        end
    end

    // total of the rows
    always_comb begin
        n_mag = '0;
        for (int i = 0; i < NL; i++) begin
            n_mag = n_mag + (r_row[i] << (i * LW));
        end
    end

    assign w_sgn = r_neg[LAT-2] ? (~r_mag + SUMW'(1)) : r_mag;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= PADW'(w_abs_a);
            r_mb <= PADW'(w_abs_b);
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    r_pp[i][j] <= r_ma[i*LW +: LW] * r_mb[j*LW +: LW];
                end
                r_row[i] <= n_row[i];
            end
            r_mag <= n_mag;
            r_neg <= {r_neg[LAT-3:0], i_a[MW-1] ^ i_b[MW-1]};
            r_p   <= rsi_pkg::PROD_W'(w_sgn);
        end
    end

    // sideband and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_p    = r_p;
    assign o_side = r_side[LAT-1];

endmodule

// ===== hdl/rsi_isqrt.sv =====
// ============================================================================
// rsi_isqrt
// Pipelined floored integer square root, one root bit per stage.
// ============================================================================
module rsi_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rsi_pkg::RAD_W-1:0]     i_rad,
    input  rsi_pkg::t_sqrt_side           i_side,
    output logic [rsi_pkg::ROOT_W-1:0]    o_root,
    output rsi_pkg::t_sqrt_side           o_side
);
    localparam int RW = rsi_pkg::ROOT_W;
    localparam int DW = rsi_pkg::RAD_W;
    localparam int SW = RW + 2;

    logic [DW-1:0] n_rad  [RW];
    logic [DW-1:0] r_rad  [RW];
    logic [SW-1:0] n_rem  [RW];
    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] n_root [RW];
    logic [RW-1:0] r_root [RW];
    rsi_pkg::t_sqrt_side n_side [RW];
    rsi_pkg::t_sqrt_side r_side [RW];

    // restoring square root step per stage
    always_comb begin
        logic [DW-1:0] rad_in;
        logic [SW-1:0] rem_in;
        logic [SW-1:0] rem_sh;
        logic [SW-1:0] trial;
        logic [RW-1:0] root_in;
        logic          ge;
        for (int k = 0; k < RW; k++) begin
            if (k == 0) begin
                rad_in    = i_rad;
                rem_in    = '0;
                root_in   = '0;
                n_side[k] = i_side;
            end else begin
                rad_in    = r_rad[k-1];
                rem_in    = r_rem[k-1];
                root_in   = r_root[k-1];
                n_side[k] = r_side[k-1];
            end
            rem_sh    = {rem_in[SW-3:0], rad_in[DW-1 -: 2]};
            trial     = {root_in, 2'b01};
            ge        = (rem_sh >= trial);
            n_rem[k]  = ge ? (rem_sh - trial) : rem_sh;
            n_root[k] = {root_in[RW-2:0], ge};
            n_rad[k]  = {rad_in[DW-3:0], 2'b00};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    // sideband and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

// ===== hdl/rsi_div.sv =====
// ============================================================================
// rsi_div
// Pipelined restoring divider for the distance: a saturation check stage,
// then one quotient bit per stage.
// ============================================================================
module rsi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rsi_pkg::DIVN_W-1:0]    i_num,
    input  logic [rsi_pkg::DEN_W-1:0]     i_den,
    input  rsi_pkg::t_div_side            i_side,
    output logic [rsi_pkg::QUO_W-1:0]     o_quo,
    output logic                          o_sat,
    output rsi_pkg::t_div_side            o_side
);
    localparam int QW  = rsi_pkg::QUO_W;
    localparam int DNW = rsi_pkg::DEN_W;
    localparam int RMW = rsi_pkg::REM_W;
    localparam int NS  = QW + 1;

    logic [DNW+QW-1:0] w_lim;
    logic [RMW-1:0]    n_rem [NS];
    logic [RMW-1:0]    r_rem [NS];
    logic [QW-1:0]     n_low [NS];
    logic [QW-1:0]     r_low [NS];
    logic [QW-1:0]     n_quo [NS];
    logic [QW-1:0]     r_quo [NS];
    logic [DNW-1:0]    n_den [NS];
    logic [DNW-1:0]    r_den [NS];
    logic [NS-1:0]     n_sat, r_sat;
    rsi_pkg::t_div_side n_side [NS];
    rsi_pkg::t_div_side r_side [NS];

    // quotient of 2^QW or more saturates
    assign w_lim = {i_den, {QW{1'b0}}};

    always_comb begin
        logic [RMW-1:0] rem_sh;
        logic           ge;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                n_rem[k]  = RMW'(i_num >> QW);
                n_low[k]  = i_num[QW-1:0];
                n_quo[k]  = '0;
                n_den[k]  = i_den;
                n_sat[k]  = ((DNW+QW)'(i_num) >= w_lim);
                n_side[k] = i_side;
            end else begin
                rem_sh    = {r_rem[k-1][RMW-2:0], r_low[k-1][QW-1]};
                ge        = (rem_sh >= RMW'(r_den[k-1]));
                n_rem[k]  = ge ? (rem_sh - RMW'(r_den[k-1])) : rem_sh;
                n_low[k]  = {r_low[k-1][QW-2:0], 1'b0};
                n_quo[k]  = {r_quo[k-1][QW-2:0], ge};
                n_den[k]  = r_den[k-1];
                n_sat[k]  = r_sat[k-1];
                n_side[k] = r_side[k-1];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
            end
            r_sat <= n_sat;
        end
    end

    // sideband and valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_side[k] <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_quo  = r_quo[NS-1];
    assign o_sat  = r_sat[NS-1];
    assign o_side = r_side[NS-1];

endmodule

// ===== hdl/ray_sphere_intersection_top.sv =====
// ============================================================================
// ray_sphere_intersection_top
// Ray-sphere hit test: nearest positive ray parameter in Q15.16.
// ============================================================================
// Usage:
//   Input channel  (i_in_valid / o_in_ready / i_ray): one ray-sphere pair per
//   transfer. Output channel (o_out_valid / i_out_ready / o_res): one result
//   per input, in order.
//   Throughput: one transfer per cycle on each side while the skid entry is
//   empty. Every stage of the quadratic (dot products, b*b - 4ac, the
//   67-stage square root and the 32-stage divider) is fully pipelined.
//   Depth: 116 register stages, mostly the square root and divider stages.
//   Stall: the output register plus a one-entry skid buffer absorb a stalled
//   receiver; the pipeline freezes only once the skid entry is occupied, so
//   input is still taken while one result waits.
//   Reset (synchronous, active low): all valid bits clear; no clearing pass,
//   the block is ready in the first cycle after reset.
// ============================================================================
module ray_sphere_intersection_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rsi_pkg::t_ray_in   i_ray,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rsi_pkg::t_ray_out  o_res
);
    localparam int OC_W   = rsi_pkg::OC_W;
    localparam int MUL_W  = rsi_pkg::MUL_W;
    localparam int PROD_W = rsi_pkg::PROD_W;
    localparam int A_W    = rsi_pkg::A_W;
    localparam int B_W    = rsi_pkg::B_W;
    localparam int C_W    = rsi_pkg::C_W;
    localparam int NUM_W  = rsi_pkg::NUM_W;
    localparam int SHN_W  = rsi_pkg::SHN_W;
    localparam int DIVN_W = rsi_pkg::DIVN_W;
    localparam int DEN_W  = rsi_pkg::DEN_W;

    logic en;

    // stage 1: oc = origin - center
    logic                          r_v1;
    logic signed [OC_W-1:0]        r_oc [3];
    logic signed [rsi_pkg::COORD_W-1:0] r_d [3];
    logic [rsi_pkg::RAD_IN_W-1:0]  r_rad1;

    // first multiplier bank
    logic signed [PROD_W-1:0]      p_dd [3];
    logic signed [PROD_W-1:0]      p_od [3];
    logic signed [PROD_W-1:0]      p_oo [3];
    logic signed [PROD_W-1:0]      p_rr;
    rsi_pkg::t_mul_side            w_rr_side;

    // stage 2: sums
    logic signed [PROD_W-1:0]      w_sum_a, w_sum_dot, w_sum_oo;
    logic                          r_v2;
    logic [A_W-1:0]                r_a2;
    logic signed [B_W-1:0]         r_b2;
    logic [rsi_pkg::OCSQ_W-1:0]    r_ocsq2;
    logic [rsi_pkg::RR_W-1:0]      r_rr2;

    // stage 3: c
    logic                          r_v3;
    logic [A_W-1:0]                r_a3;
    logic signed [B_W-1:0]         r_b3;
    logic signed [C_W-1:0]         r_c3;

    // second multiplier bank
    logic signed [PROD_W-1:0]      p_bb, p_ac;
    rsi_pkg::t_mul_side            w_bb_side;

    // stage 4: discriminant
    logic signed [PROD_W-1:0]      w_disc;
    logic [rsi_pkg::RAD_W-1:0]     r_disc4;
    rsi_pkg::t_sqrt_side           r_side4;

    // square root
    logic [rsi_pkg::ROOT_W-1:0]    w_root;
    rsi_pkg::t_sqrt_side           w_sq_side;

    // stage 5: numerators
    logic signed [NUM_W-1:0]       w_bx, w_sx;
    logic signed [NUM_W-1:0]       r_n0, r_n1;
    logic [DEN_W-1:0]              r_den5;
    logic                          r_v5, r_zero5, r_neg5;

    // stage 6: root select
    logic signed [SHN_W-1:0]       w_sn0, w_sn1, w_sden;
    logic                          w_sel0, w_ok1;
    logic [DIVN_W-1:0]             r_num6;
    logic [DEN_W-1:0]              r_den6;
    rsi_pkg::t_div_side            r_side6;

    // divider
    logic [rsi_pkg::QUO_W-1:0]     w_quo;
    logic                          w_sat;
    rsi_pkg::t_div_side            w_dv_side;
    rsi_pkg::t_ray_out             w_pipe_res;

    // output register and skid entry
    logic                          r_out_v, r_skid_v;
    rsi_pkg::t_ray_out             r_out, r_skid;

    // pipeline advances unless the skid entry holds a result
    assign en         = !r_skid_v;
    assign o_in_ready = en;

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_oc[0] <= OC_W'(i_ray.origin_x) - OC_W'(i_ray.center_x);
            r_oc[1] <= OC_W'(i_ray.origin_y) - OC_W'(i_ray.center_y);
            r_oc[2] <= OC_W'(i_ray.origin_z) - OC_W'(i_ray.center_z);
            r_d[0]  <= i_ray.dir_x;
            r_d[1]  <= i_ray.dir_y;
            r_d[2]  <= i_ray.dir_z;
            r_rad1  <= i_ray.sphere_radius;
        end
    end

    // first bank: d*d, oc*d, oc*oc per axis
    for (genvar g = 0; g < 3; g++) begin : g_axis
        rsi_mul u_dd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_a     (MUL_W'(r_d[g])),
            .i_b     (MUL_W'(r_d[g])),
            .i_side  ('0),
            .o_p     (p_dd[g]),
            .o_side  ()
        );
        rsi_mul u_od (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_a     (MUL_W'(r_oc[g])),
            .i_b     (MUL_W'(r_d[g])),
            .i_side  ('0),
            .o_p     (p_od[g]),
            .o_side  ()
        );
        rsi_mul u_oo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_a     (MUL_W'(r_oc[g])),
            .i_b     (MUL_W'(r_oc[g])),
            .i_side  ('0),
            .o_p     (p_oo[g]),
            .o_side  ()
        );
    end

    // r*r carries the valid bit
    rsi_mul u_rr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     (MUL_W'(r_rad1)),
        .i_b     (MUL_W'(r_rad1)),
        .i_side  ('{v: r_v1, a: '0, b: '0}),
        .o_p     (p_rr),
        .o_side  (w_rr_side)
    );

    // stage 2: a = d.d, b = 2 oc.d, oc.oc
    assign w_sum_a   = p_dd[0] + p_dd[1] + p_dd[2];
    assign w_sum_dot = p_od[0] + p_od[1] + p_od[2];
    assign w_sum_oo  = p_oo[0] + p_oo[1] + p_oo[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v2 <= w_rr_side.v;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2    <= w_sum_a[A_W-1:0];
            r_b2    <= {w_sum_dot[B_W-2:0], 1'b0};
            r_ocsq2 <= w_sum_oo[rsi_pkg::OCSQ_W-1:0];
            r_rr2   <= p_rr[rsi_pkg::RR_W-1:0];
            // stage 3: c = oc.oc - r*r
            r_a3    <= r_a2;
            r_b3    <= r_b2;
            r_c3    <= C_W'(r_ocsq2) - C_W'(r_rr2);
        end
    end

    // second bank: b*b and a*c
    rsi_mul u_bb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     (MUL_W'(r_b3)),
        .i_b     (MUL_W'(r_b3)),
        .i_side  ('{v: r_v3, a: r_a3, b: r_b3}),
        .o_p     (p_bb),
        .o_side  (w_bb_side)
    );

    rsi_mul u_ac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_a     (MUL_W'(r_a3)),
        .i_b     (MUL_W'(r_c3)),
        .i_side  ('0),
        .o_p     (p_ac),
        .o_side  ()
    );

    // stage 4: discriminant b*b - 4ac
    assign w_disc = p_bb - (p_ac <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side4 <= '0;
        end else if (en) begin
            r_side4.v    <= w_bb_side.v;
            r_side4.zero <= (w_bb_side.a == '0);
            r_side4.neg  <= w_disc[PROD_W-1];
            r_side4.a    <= w_bb_side.a;
            r_side4.b    <= w_bb_side.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_disc4 <= w_disc[rsi_pkg::RAD_W-1:0];
        end
    end

    rsi_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (r_disc4),
        .i_side  (r_side4),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // stage 5: -b - s, -b + s, 2a
    assign w_bx = NUM_W'(w_sq_side.b);
    assign w_sx = NUM_W'(w_root);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v5 <= w_sq_side.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n0    <= -w_bx - w_sx;
            r_n1    <= -w_bx + w_sx;
            r_den5  <= {w_sq_side.a, 1'b0};
            r_zero5 <= w_sq_side.zero;
            r_neg5  <= w_sq_side.neg;
        end
    end

    // stage 6: a root counts when its quotient is nonzero (num*2^F >= 2a)
    assign w_sn0  = SHN_W'(r_n0) <<< rsi_pkg::FRAC_BITS;
    assign w_sn1  = SHN_W'(r_n1) <<< rsi_pkg::FRAC_BITS;
    assign w_sden = SHN_W'(r_den5);
    assign w_sel0 = (w_sn0 >= w_sden);
    assign w_ok1  = (w_sn1 >= w_sden);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side6 <= '0;
        end else if (en) begin
            r_side6.v    <= r_v5;
            r_side6.hit  <= !r_zero5 && !r_neg5 && (w_sel0 || w_ok1);
            r_side6.zero <= r_zero5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num6 <= w_sel0 ? w_sn0[DIVN_W-1:0] : w_sn1[DIVN_W-1:0];
            r_den6 <= r_den5;
        end
    end

    rsi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (r_num6),
        .i_den   (r_den6),
        .i_side  (r_side6),
        .o_quo   (w_quo),
        .o_sat   (w_sat),
        .o_side  (w_dv_side)
    );

    // result formatting
    always_comb begin
        w_pipe_res.hit            = w_dv_side.hit;
        w_pipe_res.zero_direction = w_dv_side.zero;
        if (!w_dv_side.hit) begin
            w_pipe_res.distance = '0;
        end else if (w_sat) begin
            w_pipe_res.distance = '1;
        end else begin
            w_pipe_res.distance = w_quo;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            if (!r_out_v || i_out_ready) begin
                r_out_v <= w_dv_side.v;
            end else if (w_dv_side.v) begin
                r_skid_v <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_v  <= 1'b1;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!r_out_v || i_out_ready) begin
                r_out <= w_pipe_res;
            end else begin
                r_skid <= w_pipe_res;
            end
        end else if (i_out_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_res       = r_out;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without an output result");

    a_skid_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !o_in_ready)
        else $error("input taken while skid entry is full");

    a_zero_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_res.zero_direction) |-> !o_res.hit)
        else $error("zero direction reported as a hit");

    a_miss_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_res.hit) |-> (o_res.distance == '0))
        else $error("miss with nonzero distance");

endmodule

// ===== bench/tb_ray_sphere_intersection_top.sv =====
// ============================================================================
// tb_ray_sphere_intersection_top
// Self-checking bench for the ray-sphere hit test. Directed rays cover the
// zero direction, misses, tangents, inside and behind cases, tiny and
// saturated distances and field extremes; random rays follow, mostly aimed
// at their sphere. A scoreboard predicts each result with exact wide math.
// ============================================================================
module tb_ray_sphere_intersection_top;

    localparam int LATENCY   = 116;
    localparam int DOG_LIMIT = 20000;
    localparam int N_RANDOM  = 1430;
    localparam int RAY_W     = $bits(rsi_pkg::t_ray_in);

    typedef logic signed [259:0] t_wide;

    // Expected-result store and checker
    class hit_scoreboard;
        rsi_pkg::t_ray_out expected_q[$];
        int       errors;

        function automatic t_wide isqrt(t_wide x);
            t_wide root;
            t_wide bitv;
            t_wide trial;
            root = 0;
            bitv = t_wide'(1) << 256;
            while (bitv != 0) begin
                trial = root + bitv;
                if (x >= trial) begin
                    x    = x - trial;
                    root = (root >>> 1) + bitv;
                end else begin
                    root = root >>> 1;
                end
                bitv = bitv >>> 2;
            end
            return root;
        endfunction

        function automatic rsi_pkg::t_ray_out hit_distance(rsi_pkg::t_ray_in ray);
            rsi_pkg::t_ray_out res;
            t_wide    o[3];
            t_wide    d[3];
            t_wide    ce[3];
            t_wide    oc;
            t_wide    a, dot, ocsq, b, c, rad, disc, s, den, num, q;
            t_wide    maxd;
            bit       found;
            o[0] = t_wide'(ray.origin_x);
            o[1] = t_wide'(ray.origin_y);
            o[2] = t_wide'(ray.origin_z);
            d[0] = t_wide'(ray.dir_x);
            d[1] = t_wide'(ray.dir_y);
            d[2] = t_wide'(ray.dir_z);
            ce[0] = t_wide'(ray.center_x);
            ce[1] = t_wide'(ray.center_y);
            ce[2] = t_wide'(ray.center_z);
            a = 0; dot = 0; ocsq = 0;
            for (int i = 0; i < 3; i++) begin
                oc   = o[i] - ce[i];
                a    = a + d[i] * d[i];
                dot  = dot + oc * d[i];
                ocsq = ocsq + oc * oc;
            end
            b   = dot + dot;
            rad = t_wide'({1'b0, ray.sphere_radius});
            c   = ocsq - rad * rad;
            res = '0;
            if (a == 0) begin
                res.zero_direction = 1'b1;
                return res;
            end
            disc = b * b - 4 * a * c;
            if (disc < 0) return res;
            s     = isqrt(disc);
            den   = 2 * a;
            found = 0;
            q     = 0;
            for (int i = 0; i < 2 && !found; i++) begin
                num = (i == 0) ? (-b - s) : (-b + s);
                if (num <= 0) continue;
                q = (num <<< rsi_pkg::FRAC_BITS) / den;
                if (q != 0) found = 1;
            end
            if (!found) return res;
            maxd    = (t_wide'(1) <<< rsi_pkg::QUO_W) - 1;
            res.hit = 1'b1;
            res.distance = (q > maxd) ? maxd[rsi_pkg::QUO_W-1:0] : q[rsi_pkg::QUO_W-1:0];
            return res;
        endfunction

        function void note_ray(rsi_pkg::t_ray_in ray);
            expected_q = {expected_q, hit_distance(ray)};
        endfunction

        function void check_result(rsi_pkg::t_ray_out res);
            rsi_pkg::t_ray_out exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, res);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (res.hit !== exp_res.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, res.hit);
                errors++;
            end
            if (res.distance !== exp_res.distance) begin
                $display("%0t: distance expected %0h actual %0h", $time,
                         exp_res.distance, res.distance);
                errors++;
            end
            if (res.zero_direction !== exp_res.zero_direction) begin
                $display("%0t: zero_direction expected %0d actual %0d", $time,
                         exp_res.zero_direction, res.zero_direction);
                errors++;
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    rsi_pkg::t_ray_in  i_ray = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    rsi_pkg::t_ray_out o_res;

    hit_scoreboard scoreboard = new();
    bit  calm_phase = 1'b0;
    bit  hold_output = 1'b0;
    bit  stimulus_done = 1'b0;
    int  idle_cycles = 0;

    ray_sphere_intersection_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ray       (i_ray),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (o_res)
    );

    always #2 i_clk = ~i_clk;

    // Sample transfers at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) scoreboard.note_ray(i_ray);
            if (o_out_valid && i_out_ready) scoreboard.check_result(o_res);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_LIMIT) begin
            $display("ray_sphere_intersection_top test failed");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretch, one long hold-off
    always @(negedge i_clk) begin
        if (hold_output)
            i_out_ready <= 1'b0;
        else if (calm_phase)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 24);
    end

    initial begin
        wait (stimulus_done == 0 && i_rst_n);
        repeat (300) @(negedge i_clk);
        hold_output = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_output = 1'b0;
    end

    // Offer one ray and wait for its transfer; valid stays up for the next one
    task automatic send_ray(rsi_pkg::t_ray_in ray);
        while (!calm_phase && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ray      <= ray;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic rsi_pkg::t_ray_in make_ray(int sx, int sy, int sz,
                                                  int dx, int dy, int dz,
                                                  int cx, int cy, int cz, int rad);
        rsi_pkg::t_ray_in ray;
        ray.origin_x = sx; ray.origin_y = sy; ray.origin_z = sz;
        ray.dir_x = dx; ray.dir_y = dy; ray.dir_z = dz;
        ray.center_x = cx; ray.center_y = cy; ray.center_z = cz;
        ray.sphere_radius = rad[rsi_pkg::RAD_IN_W-1:0];
        return ray;
    endfunction

    // Coordinate at a scale picked at random; one choice is a full random word
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(65536)) - 32768);
            default: return 32'($signed($urandom_range(200000000)) - 100000000);
        endcase
    endfunction

    function automatic rsi_pkg::t_ray_in random_ray();
        rsi_pkg::t_ray_in ray;
        ray = RAY_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(99) < 75) begin
            // aimed ray: direction points roughly at the center, x sometimes flipped
            ray.origin_x = rand_coord();
            ray.origin_y = rand_coord();
            ray.origin_z = rand_coord();
            ray.center_x = ray.origin_x + (rand_coord() >>> $urandom_range(8));
            ray.center_y = ray.origin_y + (rand_coord() >>> $urandom_range(8));
            ray.center_z = ray.origin_z + (rand_coord() >>> $urandom_range(8));
            ray.dir_x = (ray.center_x - ray.origin_x) >>> $urandom_range(12);
            ray.dir_y = (ray.center_y - ray.origin_y) >>> $urandom_range(12);
            ray.dir_z = (ray.center_z - ray.origin_z) >>> $urandom_range(12);
            if ($urandom_range(3) == 0) ray.dir_x = -ray.dir_x;
            ray.sphere_radius = ($urandom_range(1))
                ? rsi_pkg::RAD_IN_W'(rand_coord() & 32'h7fff_ffff) : ray.sphere_radius;
            if ($urandom_range(19) == 0) begin
                ray.dir_x = 0; ray.dir_y = 0; ray.dir_z = 0;
            end
        end
        return ray;
    endfunction

    initial begin
        int one;
        int big;
        one = 32'h0001_0000;
        big = 32'h7fff_ffff;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rays
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 5*one, 0, 0, one));           // zero direction
        send_ray(make_ray(0, 0, 0, one, 0, 0, 5*one, 0, 0, one));         // hit at 4
        send_ray(make_ray(0, 0, 0, one, 0, 0, 5*one, 3*one, 0, one));     // miss
        send_ray(make_ray(0, one, 0, one, 0, 0, 5*one, 0, 0, one));       // tangent
        send_ray(make_ray(0, 0, 0, one, 0, 0, 0, 0, 0, 2*one));           // inside
        send_ray(make_ray(0, 0, 0, -one, 0, 0, 5*one, 0, 0, one));        // behind
        send_ray(make_ray(0, 0, 0, big, 0, 0, 1, 0, 0, 0));               // tiny root
        send_ray(make_ray(0, 0, 0, 1, 0, 0, big, 0, 0, one));             // saturate
        send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, big, big, big,
                          big, big, big, big));
        send_ray(make_ray(big, big, big, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, big));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, big));
        send_ray(make_ray(0, 0, 0, 0, one, 0, 0, 3*one, 0, 0));           // zero radius
        send_ray(make_ray(0, 0, 0, 0, 0, 1, 0, 0, 7*one, one));
        send_ray(make_ray(big, 0, 0, -one, 0, 0, 32'h8000_0000, 0, 0, big));
        send_ray(make_ray(0, 0, 0, one, one, one, 9*one, 9*one, 9*one, 2*one));
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        i_in_valid <= 1'b0;

        // Pause until everything has drained
        wait (scoreboard.expected_q.size() == 0);
        @(negedge i_clk);

        // Random rays; a stretch in the middle runs without idling
        for (int n = 0; n < N_RANDOM; n++) begin
            calm_phase = (n >= 600 && n < 800);
            send_ray(random_ray());
        end
        i_in_valid <= 1'b0;
        calm_phase = 1'b0;
        stimulus_done = 1'b1;

        wait (scoreboard.expected_q.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (scoreboard.errors == 0 && scoreboard.expected_q.size() == 0)
            $display("ray_sphere_intersection_top test passed");
        else
            $display("ray_sphere_intersection_top test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/rsi_pkg.sv
hdl/rsi_mul.sv
hdl/rsi_isqrt.sv
hdl/rsi_div.sv
hdl/ray_sphere_intersection_top.sv
bench/tb_ray_sphere_intersection_top.sv
